/* design/csmd_pkg.sv */
// Shared constants, codes and types of the circle smooth-minimum distance block.
// Depends on nothing; csmd_core and the top level refer to it by scoped names.
`default_nettype none

package csmd_pkg;

    // Table size and coordinate format.
    localparam int MAX_OBSTACLES = 16;
    localparam int FRAC_BITS     = 12;

    // Field widths.
    localparam int CW   = 24;   // signed coordinate
    localparam int RW   = 23;   // unsigned radius
    localparam int BW   = 16;   // beta, Q8.8
    localparam int NCFG = 5;    // obstacle count register
    localparam int DW   = 32;   // distance result

    // Internal widths.
    localparam int SQW = 52;            // squared distance and root iteration
    localparam int TW  = 36;            // scaled edge distance t
    localparam int VW  = TW + 1;        // max plus log
    localparam int NW  = VW + 8;        // dividend magnitude
    localparam int LNW = 20;            // natural log result

    // Iteration counts and fixed-point constants.
    localparam int SQRT_STEPS = 26;
    localparam int SQRT_TOP   = 50;
    localparam int SQ_STEPS   = 16;
    localparam int EXP_MW     = FRAC_BITS + 6;
    localparam int EXP_LIMIT  = 32 << FRAC_BITS;
    localparam int LN_SH      = 32 - FRAC_BITS;
    localparam int INT_LOG    = 14;
    localparam int LN2_Q16    = 45426;

    localparam logic [DW-1:0] DIST_MAX = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] DIST_MIN = 32'h8000_0000;
    localparam logic [BW-1:0] BETA_RESET = 16'd5120;

    // Operation and register codes.
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic {
        REG_SHARPNESS = 1'b0,
        REG_COUNT     = 1'b1
    } reg_idx_t;

    // Configuration seen by the sequencer.
    typedef struct packed {
        logic [BW-1:0]   beta;
        logic [NCFG-1:0] count;
    } cfg_t;

    // One query result.
    typedef struct packed {
        logic [DW-1:0] distance;
        logic          colliding;
    } res_t;

endpackage

`default_nettype wire

/* design/csmd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module csmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/csmd_mul.sv */
// Shared 32 by 32 unsigned multiplier with a registered product.
// Depends on nothing.
`default_nettype none

module csmd_mul (
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [63:0] p_reg
);

    // The product is registered and available in the cycle after the operands.
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

endmodule

`default_nettype wire

/* design/csmd_core.sv */
// Query sequencer: obstacle table, edge-distance pass, exp pass, log and divide.
// Depends on csmd_pkg, csmd_ram and csmd_mul.
`default_nettype none

module csmd_core #(
    parameter int MAX_OBSTACLES = csmd_pkg::MAX_OBSTACLES
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire csmd_pkg::cfg_t              cfg,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        op,
    input  wire logic [3:0]                  slot,
    input  wire logic signed [csmd_pkg::CW-1:0] pos_x,
    input  wire logic signed [csmd_pkg::CW-1:0] pos_y,
    input  wire logic [csmd_pkg::RW-1:0]     radius,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output csmd_pkg::res_t                   res
);

    localparam int CW   = csmd_pkg::CW;
    localparam int RW   = csmd_pkg::RW;
    localparam int TW   = csmd_pkg::TW;
    localparam int VW   = csmd_pkg::VW;
    localparam int NW   = csmd_pkg::NW;
    localparam int SQW  = csmd_pkg::SQW;
    localparam int AW   = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int NCW  = $clog2(MAX_OBSTACLES + 1);
    localparam int SUMW = 17 + $clog2(MAX_OBSTACLES);
    localparam int OW   = 2 * CW + RW;
    localparam int LSH  = csmd_pkg::LN_SH;

    typedef enum logic [19:0] {
        S_IDLE    = 20'h00001,
        S_P1_RD   = 20'h00002,
        S_P1_DX   = 20'h00004,
        S_P1_DY   = 20'h00008,
        S_P1_RR   = 20'h00010,
        S_P1_HIT  = 20'h00020,
        S_P1_SQRT = 20'h00040,
        S_P1_BD   = 20'h00080,
        S_P1_T    = 20'h00100,
        S_P2_RD   = 20'h00200,
        S_P2_EXP  = 20'h00400,
        S_P2_SQ   = 20'h00800,
        S_P2_SQW  = 20'h01000,
        S_LN_NORM = 20'h02000,
        S_LN_SQ   = 20'h04000,
        S_LN_SQW  = 20'h08000,
        S_LN_MUL  = 20'h10000,
        S_LN_V    = 20'h20000,
        S_DIV     = 20'h40000,
        S_DONE    = 20'h80000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]         idx_reg, idx_next;
    logic [NCW-1:0]        n_reg, n_next;
    logic signed [CW-1:0]  px_reg, px_next;
    logic signed [CW-1:0]  py_reg, py_next;
    logic [CW:0]           dya_reg, dya_next;
    logic [RW-1:0]         r_reg, r_next;
    logic [SQW-1:0]        s_reg, s_next;
    logic [SQW-1:0]        root_reg, root_next;
    logic [SQW-1:0]        bit_reg, bit_next;
    logic                  hit_reg, hit_next;
    logic                  dneg_reg, dneg_next;
    logic                  empty_reg, empty_next;
    logic signed [TW-1:0]  mx_reg, mx_next;
    logic [31:0]           u_reg, u_next;
    logic [SUMW-1:0]       sum_reg, sum_next;
    logic [3:0]            k_reg, k_next;
    logic [15:0]           frac_reg, frac_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic                  qneg_reg, qneg_next;
    logic [16:0]           rem_reg, rem_next;
    logic [NW-1:0]         quo_reg, quo_next;

    // Memory and multiplier hookup.
    logic                  obs_we;
    logic [AW-1:0]         obs_waddr;
    logic [OW-1:0]         obs_wdata;
    logic [OW-1:0]         obs_rdata;
    logic                  tv_we;
    logic signed [TW-1:0]  tv_rdata;
    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic [63:0]           prod;

    // Datapath helpers.
    logic [8:0]            slot_ext;
    logic                  slot_ok;
    logic [8:0]            count_ext;
    logic [NCW-1:0]        n_sat;
    logic [csmd_pkg::BW-1:0] beta;
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
    logic [RW-1:0]         cr;
    logic signed [CW:0]    dx;
    logic signed [CW:0]    dy;
    logic [CW:0]           dxa;
    logic [CW:0]           dya;
    logic [SQW-1:0]        trial;
    logic                  trial_ge;
    logic signed [26:0]    d_val;
    logic [26:0]           d_neg;
    logic [25:0]           d_abs;
    logic signed [42:0]    bd_s;
    logic signed [TW-1:0]  t_val;
    logic                  last;
    logic [TW:0]           m_e;
    logic                  e_zero;
    logic [31:0]           u_init;
    logic [31:0]           sq;
    logic [SUMW-1:0]       sum_add;
    logic [31:0]           l2;
    logic [csmd_pkg::LNW-1:0] ln_val;
    logic signed [VW-1:0]  v_val;
    logic [VW-1:0]         v_mag;
    logic [16:0]           rem_sh;
    logic                  div_ge;
    logic [31:0]           dist_neg;
    logic [31:0]           dist_pos;

    csmd_ram #(
        .WIDTH (OW),
        .DEPTH (MAX_OBSTACLES)
    ) u_obs_ram (
        .clk       (clk),
        .we        (obs_we),
        .waddr     (obs_waddr),
        .wdata     (obs_wdata),
        .raddr     (idx_reg),
        .rdata_reg (obs_rdata)
    );

    csmd_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_OBSTACLES)
    ) u_tv_ram (
        .clk       (clk),
        .we        (tv_we),
        .waddr     (idx_reg),
        .wdata     (t_val),
        .raddr     (idx_reg),
        .rdata_reg (tv_rdata)
    );

    csmd_mul u_mul (
        .clk   (clk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (prod)
    );

    // Load request decode and configuration clamps.
    assign slot_ext  = {5'b0, slot};
    assign slot_ok   = slot_ext < 9'(MAX_OBSTACLES);
    assign obs_waddr = slot_ext[AW-1:0];
    assign obs_wdata = {pos_x, pos_y, radius};
    assign count_ext = {4'b0, cfg.count};
    assign n_sat     = (count_ext > 9'(MAX_OBSTACLES)) ? NCW'(MAX_OBSTACLES)
                                                       : NCW'(count_ext);
    assign beta      = (cfg.beta == '0) ? 16'd1 : cfg.beta;

    // Offsets from the stored center.
    assign cx  = obs_rdata[OW-1 -: CW];
    assign cy  = obs_rdata[OW-CW-1 -: CW];
    assign cr  = obs_rdata[RW-1:0];
    assign dx  = {px_reg[CW-1], px_reg} - {cx[CW-1], cx};
    assign dy  = {py_reg[CW-1], py_reg} - {cy[CW-1], cy};
    assign dxa = dx[CW] ? (CW+1)'(-dx) : dx;
    assign dya = dy[CW] ? (CW+1)'(-dy) : dy;

    // One digit of the integer square root.
    assign trial    = root_reg + bit_reg;
    assign trial_ge = s_reg >= trial;

    // Edge distance and its scaled, negated form t.
    assign d_val = $signed({1'b0, root_reg[25:0]}) - $signed({4'b0, r_reg});
    assign d_neg = 27'(-d_val);
    assign d_abs = d_val[26] ? d_neg[25:0] : d_val[25:0];
    assign bd_s  = dneg_reg ? $signed({1'b0, prod[41:0]}) : -$signed({1'b0, prod[41:0]});
    assign t_val = TW'(bd_s >>> 8);
    assign last  = (NCW'(idx_reg) + NCW'(1)) == n_reg;

    // Exponent argument and the starting point of the squaring chain.
    assign m_e    = {mx_reg[TW-1], mx_reg} - {tv_rdata[TW-1], tv_rdata};
    assign e_zero = m_e > (TW+1)'(csmd_pkg::EXP_LIMIT);
    assign u_init = 32'h4000_0000
                  - 32'({m_e[csmd_pkg::EXP_MW-1:0], 14'b0} >> csmd_pkg::FRAC_BITS);
    assign sq      = prod[61:30];
    assign sum_add = sum_reg + SUMW'(sq[30:14]);

    // Log assembly and the signed dividend.
    assign l2     = {12'b0, 4'(4'(csmd_pkg::INT_LOG) - k_reg), frac_reg};
    assign ln_val = prod[LSH + csmd_pkg::LNW - 1 : LSH];
    assign v_val  = {mx_reg[TW-1], mx_reg} + $signed({17'b0, ln_val});
    assign v_mag  = v_val[VW-1] ? VW'(-v_val) : v_val;

    // One step of the restoring divider.
    assign rem_sh = {rem_reg[15:0], quo_reg[NW-1]};
    assign div_ge = rem_sh >= {1'b0, beta};

    // Result formatting with saturation.
    assign dist_neg = (quo_reg > NW'(csmd_pkg::DIST_MIN)) ? csmd_pkg::DIST_MIN
                                                          : 32'd0 - quo_reg[31:0];
    assign dist_pos = (quo_reg > NW'(csmd_pkg::DIST_MAX)) ? csmd_pkg::DIST_MAX
                                                          : quo_reg[31:0];
    assign res_valid     = (state_reg == S_DONE);
    assign res.distance  = empty_reg ? csmd_pkg::DIST_MAX : (qneg_reg ? dist_neg : dist_pos);
    assign res.colliding = hit_reg;
    assign in_ready      = (state_reg == S_IDLE);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        dya_next   = dya_reg;
        r_next     = r_reg;
        s_next     = s_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        hit_next   = hit_reg;
        dneg_next  = dneg_reg;
        empty_next = empty_reg;
        mx_next    = mx_reg;
        u_next     = u_reg;
        sum_next   = sum_reg;
        k_next     = k_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        qneg_next  = qneg_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        obs_we     = 1'b0;
        tv_we      = 1'b0;
        mul_a      = '0;
        mul_b      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (csmd_pkg::op_t'(op) == csmd_pkg::OP_LOAD)
                    begin
                        obs_we = slot_ok;
                    end
                    else
                    begin
                        px_next  = pos_x;
                        py_next  = pos_y;
                        hit_next = 1'b0;
                        idx_next = '0;
                        n_next   = n_sat;
                        if (n_sat == '0)
                        begin
                            empty_next = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            empty_next = 1'b0;
                            state_next = S_P1_RD;
                        end
                    end
                end
            end
            S_P1_RD:
            begin
                state_next = S_P1_DX;
            end
            S_P1_DX:
            begin
                mul_a      = 32'(dxa);
                mul_b      = 32'(dxa);
                dya_next   = dya;
                r_next     = cr;
                state_next = S_P1_DY;
            end
            S_P1_DY:
            begin
                s_next     = SQW'(prod[49:0]);
                mul_a      = 32'(dya_reg);
                mul_b      = 32'(dya_reg);
                state_next = S_P1_RR;
            end
            S_P1_RR:
            begin
                s_next     = s_reg + SQW'(prod[49:0]);
                mul_a      = 32'(r_reg);
                mul_b      = 32'(r_reg);
                state_next = S_P1_HIT;
            end
            S_P1_HIT:
            begin
                if (s_reg <= SQW'(prod[45:0]))
                begin
                    hit_next = 1'b1;
                end
                root_next  = '0;
                bit_next   = SQW'(1) << csmd_pkg::SQRT_TOP;
                cnt_next   = '0;
                state_next = S_P1_SQRT;
            end
            S_P1_SQRT:
            begin
                if (trial_ge)
                begin
                    s_next    = s_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(csmd_pkg::SQRT_STEPS - 1))
                begin
                    state_next = S_P1_BD;
                end
            end
            S_P1_BD:
            begin
                dneg_next  = d_val[26];
                mul_a      = 32'(d_abs);
                mul_b      = 32'(beta);
                state_next = S_P1_T;
            end
            S_P1_T:
            begin
                tv_we = 1'b1;
                if ((idx_reg == '0) || (t_val > mx_reg))
                begin
                    mx_next = t_val;
                end
                if (last)
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = S_P2_RD;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_P1_RD;
                end
            end
            S_P2_RD:
            begin
                state_next = S_P2_EXP;
            end
            S_P2_EXP:
            begin
                if (e_zero)
                begin
                    // The term underflows to zero and adds nothing.
                    if (last)
                    begin
                        u_next     = 32'(sum_reg);
                        k_next     = '0;
                        state_next = S_LN_NORM;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_P2_RD;
                    end
                end
                else
                begin
                    u_next     = u_init;
                    cnt_next   = '0;
                    state_next = S_P2_SQ;
                end
            end
            S_P2_SQ:
            begin
                mul_a      = u_reg;
                mul_b      = u_reg;
                state_next = S_P2_SQW;
            end
            S_P2_SQW:
            begin
                u_next     = sq;
                cnt_next   = cnt_reg + 6'd1;
                state_next = S_P2_SQ;
                if (cnt_reg == 6'(csmd_pkg::SQ_STEPS - 1))
                begin
                    sum_next = sum_add;
                    if (last)
                    begin
                        u_next     = 32'(sum_add);
                        k_next     = '0;
                        state_next = S_LN_NORM;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_P2_RD;
                    end
                end
            end
            S_LN_NORM:
            begin
                // Shift the sum up until its leading one sits at bit 30.
                if (u_reg[30])
                begin
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = S_LN_SQ;
                end
                else
                begin
                    u_next = u_reg << 1;
                    k_next = k_reg + 4'd1;
                end
            end
            S_LN_SQ:
            begin
                mul_a      = u_reg;
                mul_b      = u_reg;
                state_next = S_LN_SQW;
            end
            S_LN_SQW:
            begin
                frac_next  = {frac_reg[14:0], sq[31]};
                u_next     = sq[31] ? (sq >> 1) : sq;
                cnt_next   = cnt_reg + 6'd1;
                state_next = S_LN_SQ;
                if (cnt_reg == 6'(csmd_pkg::SQ_STEPS - 1))
                begin
                    state_next = S_LN_MUL;
                end
            end
            S_LN_MUL:
            begin
                mul_a      = l2;
                mul_b      = 32'(csmd_pkg::LN2_Q16);
                state_next = S_LN_V;
            end
            S_LN_V:
            begin
                // The dividend is -(v * 256); it is negative when v is positive.
                qneg_next  = ~v_val[VW-1];
                quo_next   = {v_mag, 8'b0};
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = div_ge ? (rem_sh - {1'b0, beta}) : rem_sh;
                quo_next = {quo_reg[NW-2:0], div_ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(NW - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            n_reg     <= '0;
            px_reg    <= '0;
            py_reg    <= '0;
            dya_reg   <= '0;
            r_reg     <= '0;
            s_reg     <= '0;
            root_reg  <= '0;
            bit_reg   <= '0;
            hit_reg   <= 1'b0;
            dneg_reg  <= 1'b0;
            empty_reg <= 1'b0;
            mx_reg    <= '0;
            u_reg     <= '0;
            sum_reg   <= '0;
            k_reg     <= '0;
            frac_reg  <= '0;
            cnt_reg   <= '0;
            qneg_reg  <= 1'b0;
            rem_reg   <= '0;
            quo_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            dya_reg   <= dya_next;
            r_reg     <= r_next;
            s_reg     <= s_next;
            root_reg  <= root_next;
            bit_reg   <= bit_next;
            hit_reg   <= hit_next;
            dneg_reg  <= dneg_next;
            empty_reg <= empty_next;
            mx_reg    <= mx_next;
            u_reg     <= u_next;
            sum_reg   <= sum_next;
            k_reg     <= k_next;
            frac_reg  <= frac_next;
            cnt_reg   <= cnt_next;
            qneg_reg  <= qneg_next;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
        end
    end

endmodule

`default_nettype wire

/* design/circle_smooth_min_distance_field_top.sv */
// Top level: configuration registers, query sequencer and the result register.
// Depends on csmd_pkg and csmd_core.
//
//  Channel   Handshake               Payload
//  --------  ----------------------  ------------------------------------
//  input     in_valid / in_ready     op, slot, pos_x, pos_y, radius
//  result    out_valid / out_ready   distance, colliding
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A load request is written to the table straight from idle. A query runs
// an edge pass (26-step square root), an exp pass (16 squarings on the
// shared multiplier), then the log and the bit-serial divide; with no
// obstacles it goes straight to the result.
// The input is not ready while a query is in progress. The result register
// frees the sequencer as soon as the previous result is taken or not pending.
// Reset is asynchronous; the obstacle table holds no valid state after reset.
`default_nettype none

module circle_smooth_min_distance_field_top #(
    parameter int MAX_OBSTACLES = csmd_pkg::MAX_OBSTACLES
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           op,
    input  wire logic [3:0]                     slot,
    input  wire logic signed [csmd_pkg::CW-1:0] pos_x,
    input  wire logic signed [csmd_pkg::CW-1:0] pos_y,
    input  wire logic [csmd_pkg::RW-1:0]        radius,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [csmd_pkg::DW-1:0]      distance,
    output logic                                colliding,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           cfg_index,
    input  wire logic [csmd_pkg::BW-1:0]        cfg_data
);

    logic [csmd_pkg::BW-1:0]   sharpness_reg, sharpness_next;
    logic [csmd_pkg::NCFG-1:0] count_reg, count_next;
    logic                      out_valid_reg, out_valid_next;
    logic [csmd_pkg::DW-1:0]   distance_reg, distance_next;
    logic                      colliding_reg, colliding_next;

    csmd_pkg::cfg_t cfg;
    csmd_pkg::res_t res;
    logic           res_valid;
    logic           res_ready;

    assign cfg.beta  = sharpness_reg;
    assign cfg.count = count_reg;
    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || out_ready;

    csmd_core #(
        .MAX_OBSTACLES (MAX_OBSTACLES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .slot      (slot),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .radius    (radius),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Configuration register writes.
    always_comb
    begin
        sharpness_next = sharpness_reg;
        count_next     = count_reg;
        if (cfg_valid)
        begin
            unique case (csmd_pkg::reg_idx_t'(cfg_index))
                csmd_pkg::REG_SHARPNESS: sharpness_next = cfg_data;
                csmd_pkg::REG_COUNT:     count_next = cfg_data[csmd_pkg::NCFG-1:0];
                default:                 sharpness_next = sharpness_reg;
            endcase
        end
    end

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        distance_next  = distance_reg;
        colliding_next = colliding_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            distance_next  = res.distance;
            colliding_next = res.colliding;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sharpness_reg <= csmd_pkg::BETA_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            distance_reg  <= '0;
            colliding_reg <= 1'b0;
        end
        else
        begin
            sharpness_reg <= sharpness_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            distance_reg  <= distance_next;
            colliding_reg <= colliding_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign colliding = colliding_reg;

endmodule

`default_nettype wire

/* dv/tb_circle_smooth_min_distance_field_top.sv */
// Testbench for the circle smooth-minimum distance block: directed table, then random phases.
// Depends on csmd_pkg and circle_smooth_min_distance_field_top; results checked by a predictor.
`timescale 1ns / 1ps

module tb_circle_smooth_min_distance_field_top;
    import csmd_pkg::*;

    localparam int  LIMIT_CYCLES = 12000000;
    localparam int  TAIL_CYCLES  = 64;
    localparam int  PHASES       = 28;
    localparam int  PHASE_ITEMS  = 50;

    // One row of the directed table: a register write or a request.
    typedef struct {
        bit                 is_cfg;
        reg_idx_t           cidx;
        logic [BW-1:0]      cdata;
        op_t                op;
        logic [3:0]         slot;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [RW-1:0]      r;
        bit                 fixed;
        res_t               fres;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 op;
    logic [3:0]           slot;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic [RW-1:0]        radius;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [DW-1:0] distance;
    logic                 colliding;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_index;
    logic [BW-1:0]        cfg_data;

    // Shadow copy of the obstacle table and registers.
    longint          shadow_cx [MAX_OBSTACLES];
    longint          shadow_cy [MAX_OBSTACLES];
    longint unsigned shadow_r  [MAX_OBSTACLES];
    logic [BW-1:0]   beta_reg;
    logic [NCFG-1:0] count_reg;

    res_t   pending_distances[$];
    row_t   plan[$];
    int     errors;
    int     cycles;
    int     stall_left;
    bit     rx_burst;
    bit     tx_burst;

    circle_smooth_min_distance_field_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .slot      (slot),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .radius    (radius),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .distance  (distance),
        .colliding (colliding),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Integer square root, bit by bit from the top pair.
    function automatic longint unsigned floor_root(longint unsigned s);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << SQRT_TOP;
        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            if (s >= res + bitv)
            begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // exp of a non-positive value, result in Q16.
    function automatic longint unsigned exp_q16(longint e);
        longint unsigned m;
        longint unsigned u;
        m = longint'(-e);
        if (m > (64'd32 << FRAC_BITS))
            return 0;
        u = (64'd1 << 30) - ((m << 14) >> FRAC_BITS);
        for (int i = 0; i < SQ_STEPS; i++)
            u = (u * u) >> 30;
        return u >> 14;
    endfunction

    // Natural log of a Q16 sum of at least one.
    function automatic longint ln_of_sum(longint unsigned x);
        int              msb;
        longint unsigned m;
        longint unsigned frac;
        longint unsigned l2;
        msb  = 0;
        frac = 0;
        for (int i = 0; i < 63; i++)
            if (x[i])
                msb = i;
        if (msb < 16)
            return 0;
        m = x << (30 - msb);
        for (int i = 0; i < SQ_STEPS; i++)
        begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                frac = frac | 1;
                m    = m >> 1;
            end
        end
        l2 = (longint'(msb - 16) << 16) | frac;
        return longint'((l2 * LN2_Q16) >> (32 - FRAC_BITS));
    endfunction

    // Smooth distance and hit flag of one query point against the table.
    function automatic res_t smooth_distance(logic signed [CW-1:0] qx, logic signed [CW-1:0] qy);
        res_t            r;
        int              n;
        longint          beta;
        longint          tv [MAX_OBSTACLES];
        longint          mx;
        longint          dx;
        longint          dy;
        longint          d;
        longint          bd;
        longint          v;
        longint          dval;
        longint unsigned s;
        longint unsigned sum;
        bit              hit;
        n   = (count_reg > MAX_OBSTACLES) ? MAX_OBSTACLES : int'(count_reg);
        mx  = 0;
        sum = 0;
        hit = 0;
        if (n == 0)
        begin
            r.distance  = DIST_MAX;
            r.colliding = 1'b0;
            return r;
        end
        beta = (beta_reg == 0) ? 1 : longint'(beta_reg);
        for (int i = 0; i < n; i++)
        begin
            dx = longint'(qx) - shadow_cx[i];
            dy = longint'(qy) - shadow_cy[i];
            s  = dx * dx + dy * dy;
            d  = longint'(floor_root(s)) - longint'(shadow_r[i]);
            if (s <= shadow_r[i] * shadow_r[i])
                hit = 1;
            bd = -(beta * d);
            tv[i] = (bd >= 0) ? bd / 256 : -(((-bd) + 255) / 256);
            if (i == 0 || tv[i] > mx)
                mx = tv[i];
        end
        for (int i = 0; i < n; i++)
            sum += exp_q16(tv[i] - mx);
        v    = mx + ln_of_sum(sum);
        dval = (-(v * 256)) / beta;
        if (dval > 64'sd2147483647)
            dval = 64'sd2147483647;
        if (dval < -64'sd2147483648)
            dval = -64'sd2147483648;
        r.distance  = dval[DW-1:0];
        r.colliding = hit;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // Wait until the block has nothing in flight, then let loads settle.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending_distances.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Register write; only issued while the block is idle.
    task automatic write_reg(reg_idx_t idx, logic [BW-1:0] val);
        drain_block();
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_SHARPNESS)
            beta_reg = val;
        else
            count_reg = val[NCFG-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drive one request; called at a falling edge, returns at a falling edge.
    task automatic send_request(row_t rw);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        op       <= rw.op;
        slot     <= rw.slot;
        pos_x    <= rw.x;
        pos_y    <= rw.y;
        radius   <= rw.r;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (rw.op == OP_LOAD)
        begin
            shadow_cx[rw.slot] = longint'(rw.x);
            shadow_cy[rw.slot] = longint'(rw.y);
            shadow_r[rw.slot]  = longint'(rw.r);
        end
        else if (rw.fixed)
            pending_distances = {pending_distances, rw.fres};
        else
            pending_distances = {pending_distances, smooth_distance(rw.x, rw.y)};
        @(negedge clk);
    endtask

    function automatic row_t make_req(op_t o, logic [3:0] sl, logic signed [CW-1:0] x,
                                      logic signed [CW-1:0] y, logic [RW-1:0] r);
        row_t rw;
        rw.is_cfg = 1'b0;
        rw.cidx = REG_SHARPNESS;
        rw.cdata = '0;
        rw.op = o;
        rw.slot = sl;
        rw.x = x;
        rw.y = y;
        rw.r = r;
        rw.fixed = 1'b0;
        rw.fres = '0;
        return rw;
    endfunction

    function automatic row_t make_cfg(reg_idx_t idx, logic [BW-1:0] val);
        row_t rw;
        rw = make_req(OP_LOAD, '0, '0, '0, '0);
        rw.is_cfg = 1;
        rw.cidx = idx;
        rw.cdata = val;
        return rw;
    endfunction

    // Random request that mostly lands near a used obstacle.
    function automatic row_t random_request();
        row_t   rw;
        int     k;
        int     n;
        longint off;
        n = (count_reg > MAX_OBSTACLES) ? MAX_OBSTACLES : int'(count_reg);
        if ($urandom_range(0, 2) == 0)
        begin
            rw = make_req(OP_LOAD, 4'($urandom_range(0, 15)), '0, '0, '0);
            if ($urandom_range(0, 9) == 0)
            begin
                rw.x = CW'($urandom);
                rw.y = CW'($urandom);
                rw.r = RW'($urandom);
            end
            else
            begin
                rw.x = CW'(int'($urandom_range(0, 131071)) - 65536);
                rw.y = CW'(int'($urandom_range(0, 131071)) - 65536);
                rw.r = RW'($urandom_range(0, 16384));
            end
        end
        else
        begin
            rw = make_req(OP_QUERY, 4'($urandom), '0, '0, RW'($urandom));
            if ($urandom_range(0, 9) == 0 || n == 0)
            begin
                rw.x = CW'($urandom);
                rw.y = CW'($urandom);
            end
            else
            begin
                k   = int'($urandom_range(0, n - 1));
                off = longint'(shadow_r[k]) + 64;
                if (off > 1000000)
                    off = 1000000;
                rw.x = CW'(shadow_cx[k] + longint'($urandom_range(0, 2 * off)) - off);
                rw.y = CW'(shadow_cy[k] + longint'($urandom_range(0, 2 * off)) - off);
            end
        end
        return rw;
    endfunction

    // Receiver stall: each result draws its own wait, with stall-free stretches.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Result check against the oldest expectation.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_distances.size() == 0)
            begin
                report_mismatch("unexpected result distance", distance, 0);
            end
            else
            begin
                want = pending_distances.pop_front();
                if (distance !== want.distance)
                    report_mismatch("distance", distance, $signed(want.distance));
                if (colliding !== want.colliding)
                    report_mismatch("colliding", colliding, want.colliding);
            end
            if (($urandom_range(0, 99)) == 0)
                rx_burst = ~rx_burst;
            stall_left <= rx_burst ? 0 : $urandom_range(0, 12);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        res_t empty_res;
        row_t rw;
        int   pick;
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = OP_LOAD;
        slot       = '0;
        pos_x      = '0;
        pos_y      = '0;
        radius     = '0;
        out_ready  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_SHARPNESS;
        cfg_data   = '0;
        errors     = 0;
        cycles     = 0;
        stall_left = 0;
        rx_burst   = 0;
        tx_burst   = 0;
        beta_reg   = BETA_RESET;
        count_reg  = '0;
        for (int i = 0; i < MAX_OBSTACLES; i++)
        begin
            shadow_cx[i] = 0;
            shadow_cy[i] = 0;
            shadow_r[i]  = 0;
        end
        empty_res.distance  = DIST_MAX;
        empty_res.colliding = 1'b0;

        // Directed table: empty table first, then a full load and edge settings.
        rw = make_req(OP_QUERY, 4'hF, 24'sh000000, 24'sh000000, 23'h7FFFFF);
        rw.fixed = 1;
        rw.fres = empty_res;
        plan = {plan, rw};
        rw = make_req(OP_QUERY, 4'h0, 24'sh7FFFFF, -24'sh800000, 23'h000000);
        rw.fixed = 1;
        rw.fres = empty_res;
        plan = {plan, rw};
        plan = {plan, make_req(OP_LOAD, 4'h0, -24'sh800000, 24'sh7FFFFF, 23'h000000)};
        plan = {plan, make_req(OP_LOAD, 4'hF, 24'sh7FFFFF, -24'sh800000, 23'h7FFFFF)};
        for (int i = 1; i < 15; i++)
            plan = {plan, make_req(OP_LOAD, 4'(i), CW'(i * 8192), CW'(-i * 4096),
                                   RW'(i * 1024))};
        plan = {plan, make_cfg(REG_COUNT, 16'd16)};
        plan = {plan, make_req(OP_QUERY, 4'h0, 24'sh002000, -24'sh001000, 23'h7FFFFF)};
        plan = {plan, make_cfg(REG_SHARPNESS, 16'd0)};
        plan = {plan, make_req(OP_QUERY, 4'h0, 24'sh000000, 24'sh000000, 23'h000000)};
        plan = {plan, make_cfg(REG_SHARPNESS, 16'hFFFF)};
        plan = {plan, make_req(OP_QUERY, 4'h0, -24'sh800000, 24'sh7FFFFF, 23'h000000)};
        plan = {plan, make_cfg(REG_COUNT, 16'hFFFF)};
        plan = {plan, make_req(OP_QUERY, 4'h0, 24'sh7FFFFF, 24'sh7FFFFF, 23'h000000)};

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].cidx, plan[i].cdata);
            else
                send_request(plan[i]);
        end

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            pick = $urandom_range(0, 7);
            case (pick)
                0: write_reg(REG_SHARPNESS, 16'd1);
                1: write_reg(REG_SHARPNESS, 16'hFFFF);
                2: write_reg(REG_SHARPNESS, BETA_RESET);
                default: write_reg(REG_SHARPNESS, 16'($urandom));
            endcase
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_reg(REG_COUNT, 16'd0);
            else if (pick == 1 && ph < PHASES - 1)
                write_reg(REG_COUNT, 16'($urandom_range(16, 31) | ($urandom & 16'hFFE0)));
            else
                write_reg(REG_COUNT, 16'($urandom_range(1, 4)));
            tx_burst = (ph % 4 == 1);
            for (int it = 0; it < PHASE_ITEMS; it++)
            begin
                if (it == PHASE_ITEMS / 2 && ph % 3 == 0)
                    drain_block();
                send_request(random_request());
            end
        end

        in_valid <= 1'b0;
        while (pending_distances.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
